// ===== rtl/pdjm_pkg.sv =====
// Package for the packet delay and jitter monitor: sequencer state type,
// fixed field widths and the deviation magnitude helper. No dependencies.
`default_nettype none
package pdjm_pkg;

   localparam int MISS_W    = 31;
   localparam int MEAN_D_W  = 40;
   localparam int MEAN_G_W  = 39;
   localparam int ROOT_W    = 40;
   localparam int SQ_W      = 2 * ROOT_W;
   localparam int DEV_W     = 42;
   localparam int MAG_W     = DEV_W - 1;
   localparam int FIVE_W    = ROOT_W + 3;
   localparam int REM_W     = ROOT_W + 3;
   localparam int Q_SHIFT   = 8;
   localparam logic [30:0] GAP_MAX = 31'h7FFF_FFFF;

   typedef enum logic [4:0] {
      IDLE,
      UPDATE,
      MEAN_LOAD,
      MEAN_DIV,
      MEAN_END,
      WALK_RD,
      WALK_DEV,
      MUL0,
      MUL1,
      MUL2,
      MUL3,
      VAR_LOAD,
      VAR_DIV,
      SQRT_LOAD,
      SQRT,
      SQRT_END,
      OUT
   } pdjm_state_type;

   function automatic logic [MAG_W-1:0] dev_mag(input logic signed [DEV_W-1:0] a,
                                                input logic signed [DEV_W-1:0] b);
      logic signed [DEV_W-1:0] diff;
      diff = a - b;
      return diff[DEV_W-1] ? MAG_W'(-diff) : diff[MAG_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/packet_delay_jitter_monitor.sv =====
// Packet delay and inter-arrival jitter monitor: sliding windows, means,
// population deviations and abnormal flags. Depends on pdjm_pkg.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | kind, pkt_delay, arrival_ns, seq_number
//   rsp_    | out       | rsp_valid/rsp_stall | missed, means, jitters, abnormal flags
//
// A restart item gives no result. A sample item runs from acceptance to the
// result load through the shared bit-serial divider, the shared 32x32 multiplier
// walk over the filled entries of the window memory and the bit-pair square root.
// Reset is synchronous and empties both windows through the fill count.
// req_stall is high while a sample is at work; a waiting result holds in the
// output register and does not block the next item, but that item's result
// holds in OUT, with req_stall high, until the output register is taken.
`default_nettype none
module packet_delay_jitter_monitor #(
   parameter int WINDOW_DEPTH = 64
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire                                   req_kind,
   input  wire  signed [31:0]                    req_pkt_delay,
   input  wire         [63:0]                    req_arrival_ns,
   input  wire         [31:0]                    req_seq_number,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic        [pdjm_pkg::MISS_W-1:0]    rsp_missed_packets,
   output logic signed [pdjm_pkg::MEAN_D_W-1:0]  rsp_mean_delay,
   output logic        [pdjm_pkg::ROOT_W-1:0]    rsp_delay_jitter,
   output logic        [pdjm_pkg::MEAN_G_W-1:0]  rsp_mean_gap,
   output logic        [pdjm_pkg::ROOT_W-1:0]    rsp_gap_jitter,
   output logic                                  rsp_delay_abnormal,
   output logic                                  rsp_gap_abnormal
);

   localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int DTOT_W = 32 + CNT_W;
   localparam int GTOT_W = 31 + CNT_W;
   localparam int ACC_W  = 82 + CNT_W;
   localparam int STEP_W = $clog2(ACC_W + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(WINDOW_DEPTH);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

   pdjm_pkg::pdjm_state_type state_ff, state_in;

   logic signed [31:0] dmem [WINDOW_DEPTH];
   logic        [30:0] gmem [WINDOW_DEPTH];
   logic signed [31:0] rd_d_ff;
   logic        [30:0] rd_g_ff;
   logic [SLOT_W-1:0]  rd_addr;

   logic                      win_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic [CNT_W-1:0]          filled_ff;
   logic signed [DTOT_W-1:0]  dtot_ff;
   logic [GTOT_W-1:0]         gtot_ff;
   logic [31:0]               prev_seq_ff;
   logic [63:0]               prev_arr_ff;
   logic                      seen_ff;
   logic signed [31:0]        cur_delay_ff;
   logic [30:0]               cur_gap_ff;
   logic [pdjm_pkg::MISS_W-1:0] missed_ff;
   logic signed [pdjm_pkg::MEAN_D_W-1:0] mean_d_ff;
   logic [pdjm_pkg::MEAN_G_W-1:0] mean_g_ff;
   logic [pdjm_pkg::ROOT_W-1:0] jit_d_ff, jit_g_ff;
   logic [CNT_W-1:0]          idx_ff;
   logic [pdjm_pkg::MAG_W-1:0] m_ff;
   logic [63:0]               prod_ff;
   logic [ACC_W-1:0]          acc_ff;
   logic [ACC_W-1:0]          dq_ff;
   logic [CNT_W-1:0]          dr_ff;
   logic [STEP_W-1:0]         cnt_ff;
   logic [pdjm_pkg::ROOT_W-1:0] root_ff;
   logic [pdjm_pkg::REM_W-1:0] rem_ff;
   logic [pdjm_pkg::SQ_W-1:0] src_ff;
   logic                      rsp_valid_ff;

   logic accept, rsp_load;
   logic [31:0] sdiff, sdiff_m1;
   logic [63:0] gdiff;
   logic [30:0] gap_in;
   logic [pdjm_pkg::MISS_W-1:0] missed_in;
   logic signed [31:0] old_d;
   logic [30:0] old_g;
   logic [DTOT_W-1:0] dabs;
   logic [ACC_W-1:0] mean_dividend;
   logic [pdjm_pkg::MEAN_D_W-1:0] quot_d;
   logic signed [pdjm_pkg::DEV_W-1:0] walk_x, walk_m;
   logic [8:0]  mh;
   logic [31:0] ml, mul_a, mul_b;
   logic [63:0] product;
   logic [CNT_W:0] dt, dn;
   logic           dge;
   logic [pdjm_pkg::REM_W-1:0] st, strial;
   logic [pdjm_pkg::MAG_W-1:0] dm_cur, gm_cur;
   logic [pdjm_pkg::FIVE_W-1:0] five_d, five_g;
   logic flag_d, flag_g;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != pdjm_pkg::IDLE);
   assign rsp_load  = (state_ff == pdjm_pkg::OUT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      sdiff     = req_seq_number - prev_seq_ff;
      sdiff_m1  = sdiff - 32'd1;
      missed_in = (!sdiff[31] && sdiff > 32'd1) ? sdiff_m1[30:0] : '0;
      gdiff     = req_arrival_ns - prev_arr_ff;
      if (!seen_ff) begin
         gap_in = '0;
      end else if (|gdiff[63:31]) begin
         gap_in = pdjm_pkg::GAP_MAX;
      end else begin
         gap_in = gdiff[30:0];
      end
      old_d = (filled_ff == FULL) ? rd_d_ff : '0;
      old_g = (filled_ff == FULL) ? rd_g_ff : '0;
      dabs  = dtot_ff[DTOT_W-1] ? DTOT_W'(-dtot_ff) : DTOT_W'(dtot_ff);
      if (win_ff) begin
         mean_dividend = ACC_W'({gtot_ff, 8'd0});
      end else begin
         mean_dividend = ACC_W'({dabs, 8'd0});
      end
      quot_d = dq_ff[pdjm_pkg::MEAN_D_W-1:0];
      if (win_ff) begin
         walk_x = {3'd0, rd_g_ff, 8'd0};
         walk_m = {3'd0, mean_g_ff};
      end else begin
         walk_x = {{2{rd_d_ff[31]}}, rd_d_ff, 8'd0};
         walk_m = {{2{mean_d_ff[39]}}, mean_d_ff};
      end
      mh = m_ff[40:32];
      ml = m_ff[31:0];
      case (state_ff)
         pdjm_pkg::MUL1: begin
            mul_a = {23'd0, mh};
            mul_b = ml;
         end
         pdjm_pkg::MUL2: begin
            mul_a = {23'd0, mh};
            mul_b = {23'd0, mh};
         end
         default: begin
            mul_a = ml;
            mul_b = ml;
         end
      endcase
      product = mul_a * mul_b;
      dt  = {dr_ff, dq_ff[ACC_W-1]};
      dn  = {1'b0, filled_ff};
      dge = (dt >= dn);
      st     = {rem_ff[pdjm_pkg::REM_W-3:0], src_ff[pdjm_pkg::SQ_W-1 -: 2]};
      strial = {1'b0, root_ff, 2'b01};
      dm_cur = pdjm_pkg::dev_mag({{2{cur_delay_ff[31]}}, cur_delay_ff, 8'd0},
                                 {{2{mean_d_ff[39]}}, mean_d_ff});
      gm_cur = pdjm_pkg::dev_mag({3'd0, cur_gap_ff, 8'd0}, {3'd0, mean_g_ff});
      five_d = {1'b0, jit_d_ff, 2'b00} + pdjm_pkg::FIVE_W'(jit_d_ff);
      five_g = {1'b0, jit_g_ff, 2'b00} + pdjm_pkg::FIVE_W'(jit_g_ff);
      flag_d = {2'b00, dm_cur} > five_d;
      flag_g = {2'b00, gm_cur} > five_g;
      rd_addr = (state_ff == pdjm_pkg::IDLE) ? slot_ff : idx_ff[SLOT_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pdjm_pkg::IDLE:      if (accept && !req_kind) state_in = pdjm_pkg::UPDATE;
         pdjm_pkg::UPDATE:    state_in = pdjm_pkg::MEAN_LOAD;
         pdjm_pkg::MEAN_LOAD: state_in = pdjm_pkg::MEAN_DIV;
         pdjm_pkg::MEAN_DIV:  if (cnt_ff == STEP_W'(1)) state_in = pdjm_pkg::MEAN_END;
         pdjm_pkg::MEAN_END:  state_in = win_ff ? pdjm_pkg::WALK_RD : pdjm_pkg::MEAN_LOAD;
         pdjm_pkg::WALK_RD:   state_in = pdjm_pkg::WALK_DEV;
         pdjm_pkg::WALK_DEV:  state_in = pdjm_pkg::MUL0;
         pdjm_pkg::MUL0:      state_in = pdjm_pkg::MUL1;
         pdjm_pkg::MUL1:      state_in = pdjm_pkg::MUL2;
         pdjm_pkg::MUL2:      state_in = pdjm_pkg::MUL3;
         pdjm_pkg::MUL3: begin
            if (idx_ff + CNT_W'(1) == filled_ff) state_in = pdjm_pkg::VAR_LOAD;
            else state_in = pdjm_pkg::WALK_RD;
         end
         pdjm_pkg::VAR_LOAD:  state_in = pdjm_pkg::VAR_DIV;
         pdjm_pkg::VAR_DIV:   if (cnt_ff == STEP_W'(1)) state_in = pdjm_pkg::SQRT_LOAD;
         pdjm_pkg::SQRT_LOAD: begin
            if (|dq_ff[ACC_W-1:pdjm_pkg::SQ_W]) state_in = pdjm_pkg::SQRT_END;
            else state_in = pdjm_pkg::SQRT;
         end
         pdjm_pkg::SQRT:      if (cnt_ff == STEP_W'(1)) state_in = pdjm_pkg::SQRT_END;
         pdjm_pkg::SQRT_END:  state_in = win_ff ? pdjm_pkg::OUT : pdjm_pkg::WALK_RD;
         pdjm_pkg::OUT:       if (rsp_load) state_in = pdjm_pkg::IDLE;
         default:             state_in = pdjm_pkg::IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= pdjm_pkg::IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      if (state_ff == pdjm_pkg::UPDATE) begin
         dmem[slot_ff] <= cur_delay_ff;
         gmem[slot_ff] <= cur_gap_ff;
      end
      rd_d_ff <= dmem[rd_addr];
      rd_g_ff <= gmem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff       <= 1'b0;
         slot_ff      <= '0;
         filled_ff    <= '0;
         dtot_ff      <= '0;
         gtot_ff      <= '0;
         prev_seq_ff  <= '0;
         prev_arr_ff  <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            pdjm_pkg::IDLE: begin
               if (accept && req_kind) begin
                  slot_ff     <= '0;
                  filled_ff   <= '0;
                  dtot_ff     <= '0;
                  gtot_ff     <= '0;
                  seen_ff     <= 1'b0;
                  prev_seq_ff <= req_seq_number;
               end else if (accept) begin
                  prev_seq_ff <= req_seq_number;
                  prev_arr_ff <= req_arrival_ns;
                  seen_ff     <= 1'b1;
                  win_ff      <= 1'b0;
               end
            end
            pdjm_pkg::UPDATE: begin
               dtot_ff <= dtot_ff + DTOT_W'(cur_delay_ff) - DTOT_W'(old_d);
               gtot_ff <= gtot_ff + GTOT_W'(cur_gap_ff) - GTOT_W'(old_g);
               slot_ff <= (slot_ff == LAST_SLOT) ? '0 : slot_ff + SLOT_W'(1);
               if (filled_ff != FULL) filled_ff <= filled_ff + CNT_W'(1);
            end
            pdjm_pkg::MEAN_END: win_ff <= ~win_ff;
            pdjm_pkg::SQRT_END: if (!win_ff) win_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         pdjm_pkg::IDLE: begin
            if (accept && !req_kind) begin
               cur_delay_ff <= req_pkt_delay;
               cur_gap_ff   <= gap_in;
               missed_ff    <= missed_in;
            end
         end
         pdjm_pkg::MEAN_LOAD, pdjm_pkg::VAR_LOAD: begin
            dq_ff  <= (state_ff == pdjm_pkg::MEAN_LOAD) ? mean_dividend : acc_ff;
            dr_ff  <= '0;
            cnt_ff <= STEP_W'(ACC_W);
         end
         pdjm_pkg::MEAN_DIV, pdjm_pkg::VAR_DIV: begin
            dr_ff  <= dge ? CNT_W'(dt - dn) : dt[CNT_W-1:0];
            dq_ff  <= {dq_ff[ACC_W-2:0], dge};
            cnt_ff <= cnt_ff - STEP_W'(1);
         end
         pdjm_pkg::MEAN_END: begin
            if (win_ff) begin
               mean_g_ff <= dq_ff[pdjm_pkg::MEAN_G_W-1:0];
               idx_ff    <= '0;
               acc_ff    <= '0;
            end else begin
               mean_d_ff <= dtot_ff[DTOT_W-1] ? $signed(-quot_d) : $signed(quot_d);
            end
         end
         pdjm_pkg::WALK_DEV: m_ff <= pdjm_pkg::dev_mag(walk_x, walk_m);
         pdjm_pkg::MUL0: prod_ff <= product;
         pdjm_pkg::MUL1: begin
            acc_ff  <= acc_ff + ACC_W'(prod_ff);
            prod_ff <= product;
         end
         pdjm_pkg::MUL2: begin
            acc_ff  <= acc_ff + (ACC_W'(prod_ff) << 33);
            prod_ff <= product;
         end
         pdjm_pkg::MUL3: begin
            acc_ff <= acc_ff + (ACC_W'(prod_ff) << 64);
            idx_ff <= idx_ff + CNT_W'(1);
         end
         pdjm_pkg::SQRT_LOAD: begin
            src_ff  <= dq_ff[pdjm_pkg::SQ_W-1:0];
            rem_ff  <= '0;
            root_ff <= (|dq_ff[ACC_W-1:pdjm_pkg::SQ_W]) ? '1 : '0;
            cnt_ff  <= STEP_W'(pdjm_pkg::ROOT_W);
         end
         pdjm_pkg::SQRT: begin
            if (st >= strial) begin
               rem_ff  <= st - strial;
               root_ff <= {root_ff[pdjm_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= st;
               root_ff <= {root_ff[pdjm_pkg::ROOT_W-2:0], 1'b0};
            end
            src_ff <= {src_ff[pdjm_pkg::SQ_W-3:0], 2'b00};
            cnt_ff <= cnt_ff - STEP_W'(1);
         end
         pdjm_pkg::SQRT_END: begin
            if (win_ff) begin
               jit_g_ff <= root_ff;
            end else begin
               jit_d_ff <= root_ff;
               idx_ff   <= '0;
               acc_ff   <= '0;
            end
         end
         pdjm_pkg::OUT: begin
            if (rsp_load) begin
               rsp_missed_packets <= missed_ff;
               rsp_mean_delay     <= mean_d_ff;
               rsp_delay_jitter   <= jit_d_ff;
               rsp_mean_gap       <= mean_g_ff;
               rsp_gap_jitter     <= jit_g_ff;
               rsp_delay_abnormal <= flag_d;
               rsp_gap_abnormal   <= flag_g;
            end
         end
         default: ;
      endcase
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FULL) else $error("fill count beyond window depth");

   a_sample_starts: assert property (@(posedge clock) disable iff (reset)
      accept && !req_kind |=> state_ff == pdjm_pkg::UPDATE)
      else $error("sample item did not start the update");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == pdjm_pkg::WALK_RD |-> idx_ff < filled_ff)
      else $error("window walk past filled entries");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pdjm_pkg::OUT))
      else $error("result raised outside the output step");

endmodule
`default_nettype wire
